// ===== hw/rtl/tcp_sce_pkg.sv =====
// Shared types and constants of the single-connection TCP engine.
package tcp_sce_pkg;

	// Command codes of a request
	typedef enum logic [2:0] {
		OP_SEGMENT = 3'd0,
		OP_OPEN    = 3'd1,
		OP_SEND    = 3'd2,
		OP_CLOSE   = 3'd3,
		OP_ABORT   = 3'd4
	} opcode_t;

	// Connection states
	typedef enum logic [2:0] {
		ST_CLOSED     = 3'd0,
		ST_SYN_SENT   = 3'd1,
		ST_ESTAB      = 3'd2,
		ST_FIN_WAIT1  = 3'd3,
		ST_FIN_WAIT2  = 3'd4,
		ST_CLOSE_WAIT = 3'd5,
		ST_LAST_ACK   = 3'd6
	} conn_state_t;

	// Final status codes
	typedef enum logic [2:0] {
		RS_OK          = 3'd0,
		RS_DROP        = 3'd1,
		RS_NOT_ALLOWED = 3'd2,
		RS_TOO_LONG    = 3'd3,
		RS_RESET       = 3'd4
	} res_status_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_PEER_ADDR = 2'd0,
		CFG_PEER_PORT = 2'd1,
		CFG_OWN_PORT  = 2'd2
	} cfg_index_t;

	// Result kinds
	localparam logic KIND_DESC   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// TCP flag bits
	localparam logic [7:0] FL_FIN = 8'h01;
	localparam logic [7:0] FL_SYN = 8'h02;
	localparam logic [7:0] FL_RST = 8'h04;
	localparam logic [7:0] FL_PSH = 8'h08;
	localparam logic [7:0] FL_ACK = 8'h10;

	localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
	localparam int unsigned MAX_RESULTS   = 3;

	// One request
	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] src_address;
		logic [15:0] src_port_number;
		logic [15:0] dst_port_number;
		logic [31:0] seg_seq;
		logic [31:0] seg_ack;
		logic [7:0]  seg_flags;
		logic [3:0]  header_words;
		logic [15:0] seg_length;
		logic [31:0] initial_seq;
		logic [10:0] send_length;
	} cmd_t;

	// One result
	typedef struct packed {
		logic        kind;
		logic [4:0]  tx_flags;
		logic [31:0] tx_seq;
		logic [31:0] tx_ack;
		logic [10:0] tx_length;
		logic [15:0] deliver_length;
		logic [2:0]  conn_state;
		logic [2:0]  status;
		logic        peer_finished;
		logic        reset_flag;
		logic        last;
	} res_t;

	// All results of one request, first in slot 0, count from 1 to 3
	typedef struct packed {
		res_t [MAX_RESULTS-1:0] slot;
		logic [1:0]             count;
	} batch_t;

endpackage

// ===== hw/rtl/tcp_sce_if.sv =====
// Request and result channel interfaces of the TCP engine.
interface tcp_sce_cmd_if
	import tcp_sce_pkg::*;
;
	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tcp_sce_res_if
	import tcp_sce_pkg::*;
;
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tcp_single_connection_engine.sv =====
// Top level of the client-side single-connection TCP control engine.
// A request (received-segment header or open, send, close, abort command) is taken
// into an input register and decided there; its one to three results
// (transmit descriptors, then a final status with last set) leave from a result
// buffer one per cycle while the receiver is ready. The first result is registered
// in the buffer after the request has been decided in the input register. Requests
// flow back to back; a request waits in the input register until the results of
// the one before have all left the single result port of the buffer. Write the
// configuration registers only while no request is pending.
module tcp_single_connection_engine
	import tcp_sce_pkg::*;
#(
	parameter int unsigned MAX_SEGMENT_BYTES = 1300
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	tcp_sce_cmd_if.sink   cmd,
	tcp_sce_res_if.source res
);

	logic [31:0] peer_addr_q;
	logic [15:0] remote_port_q;
	logic [15:0] own_port_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_addr_q   <= '0;
			remote_port_q <= '0;
			own_port_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PEER_ADDR: peer_addr_q   <= cfg_data;
				CFG_PEER_PORT: remote_port_q <= cfg_data[15:0];
				CFG_OWN_PORT:  own_port_q    <= cfg_data[15:0];
				default: begin
					peer_addr_q <= peer_addr_q;
				end
			endcase
		end
	end

	cmd_t   cmd_s1;
	logic   vld_s1;
	logic   load;
	logic   can_load;
	batch_t batch;

	assign load      = vld_s1 && can_load;
	assign cmd.ready = !vld_s1 || load;

	// Hold the accepted request until its results go into the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	tcp_sce_core #(
		.MAX_SEGMENT_BYTES(MAX_SEGMENT_BYTES)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (load),
		.cmd              (cmd_s1),
		.peer_address     (peer_addr_q),
		.peer_port_number (remote_port_q),
		.own_port_number  (own_port_q),
		.batch            (batch)
	);

	tcp_sce_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.batch    (batch),
		.can_load (can_load),
		.res      (res)
	);

endmodule

// ===== hw/rtl/tcp_sce_core.sv =====
// Connection state, sequence counters and result formation for one request.
module tcp_sce_core
	import tcp_sce_pkg::*;
#(
	parameter int unsigned MAX_SEGMENT_BYTES = 1300
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  cmd_t        cmd,
	input  logic [31:0] peer_address,
	input  logic [15:0] peer_port_number,
	input  logic [15:0] own_port_number,
	output batch_t      batch
);

	localparam logic [10:0] MaxLen = 11'(MAX_SEGMENT_BYTES);

	conn_state_t st_q, st_nxt;
	logic [31:0] snd_q, snd_nxt;
	logic [31:0] una_q, una_nxt;
	logic [31:0] rcv_q, rcv_nxt;
	logic        fin_q, fin_nxt;
	logic        rst_q, rst_nxt;

	// Segment analysis
	logic [5:0]  off;
	logic [15:0] dlen;
	logic        malformed, foreign, drop_seg;
	logic        has_data, delivered, fin_ok, ack_adv, synack_ok;
	logic [31:0] seq_end, rcv_data, rcv1, rcv2, una1, d1, d2, seq_p1;
	conn_state_t st_fin;
	logic        fin1;

	always_comb begin
		off       = {cmd.header_words, 2'b00};
		malformed = (cmd.seg_length < MIN_HDR_BYTES) || (16'(off) < MIN_HDR_BYTES) ||
			(16'(off) > cmd.seg_length);
		foreign   = (cmd.src_port_number != peer_port_number) ||
			(cmd.dst_port_number != own_port_number) || (cmd.src_address != peer_address);
		drop_seg  = (st_q == ST_CLOSED) || malformed || foreign;
		dlen      = cmd.seg_length - 16'(off);
		has_data  = (dlen != 16'd0);
		delivered = has_data && (cmd.seg_seq == rcv_q);
		seq_end   = cmd.seg_seq + 32'(dlen);
		rcv_data  = rcv_q + 32'(dlen);
		fin_ok    = ((cmd.seg_flags & FL_FIN) != 8'd0) && (delivered || seq_end == rcv_q);
		rcv1      = delivered ? rcv_data : rcv_q;
		rcv2      = fin_ok ? rcv1 + 32'd1 : rcv1;
		d1        = cmd.seg_ack - una_q;
		d2        = cmd.seg_ack - snd_q;
		ack_adv   = ((cmd.seg_flags & FL_ACK) != 8'd0) && (d1 != 32'd0) && !d1[31] &&
			((d2 == 32'd0) || d2[31]);
		una1      = ack_adv ? cmd.seg_ack : una_q;
		synack_ok = ((cmd.seg_flags & (FL_SYN | FL_ACK)) == (FL_SYN | FL_ACK)) &&
			(cmd.seg_ack == snd_q);
		seq_p1    = cmd.seg_seq + 32'd1;
		fin1      = fin_q || fin_ok;
		// state after the peer's FIN
		st_fin    = st_q;
		if (fin_ok) begin
			if (st_q == ST_ESTAB) begin
				st_fin = ST_CLOSE_WAIT;
			end else if (st_q == ST_FIN_WAIT1 || st_q == ST_FIN_WAIT2) begin
				st_fin = ST_CLOSED;
			end
		end
	end

	// Next state
	always_comb begin
		st_nxt  = st_q;
		snd_nxt = snd_q;
		una_nxt = una_q;
		rcv_nxt = rcv_q;
		fin_nxt = fin_q;
		rst_nxt = rst_q;
		case (cmd.opcode)
			OP_SEGMENT: begin
				if (!drop_seg) begin
					if ((cmd.seg_flags & FL_RST) != 8'd0) begin
						rst_nxt = 1'b1;
						st_nxt  = ST_CLOSED;
					end else if (st_q == ST_SYN_SENT) begin
						if (synack_ok) begin
							una_nxt = cmd.seg_ack;
							rcv_nxt = seq_p1;
							st_nxt  = ST_ESTAB;
						end
					end else begin
						una_nxt = una1;
						rcv_nxt = rcv2;
						fin_nxt = fin1;
						st_nxt  = st_fin;
						if (st_fin == ST_FIN_WAIT1 && una1 == snd_q) begin
							st_nxt = fin1 ? ST_CLOSED : ST_FIN_WAIT2;
						end else if (st_fin == ST_LAST_ACK && una1 == snd_q) begin
							st_nxt = ST_CLOSED;
						end
					end
				end
			end
			OP_OPEN: begin
				if (st_q == ST_CLOSED) begin
					snd_nxt = cmd.initial_seq + 32'd1;
					una_nxt = cmd.initial_seq;
					rcv_nxt = 32'd0;
					fin_nxt = 1'b0;
					rst_nxt = 1'b0;
					st_nxt  = ST_SYN_SENT;
				end
			end
			OP_SEND: begin
				if ((st_q == ST_ESTAB || st_q == ST_CLOSE_WAIT) && cmd.send_length <= MaxLen &&
					snd_q == una_q) begin
					snd_nxt = snd_q + 32'(cmd.send_length);
				end
			end
			OP_CLOSE: begin
				if (st_q == ST_ESTAB || st_q == ST_CLOSE_WAIT) begin
					snd_nxt = snd_q + 32'd1;
					st_nxt  = (st_q == ST_ESTAB) ? ST_FIN_WAIT1 : ST_LAST_ACK;
				end else begin
					st_nxt = ST_CLOSED;
				end
			end
			OP_ABORT: begin
				st_nxt = ST_CLOSED;
			end
			default: begin
				st_nxt = st_q;
			end
		endcase
	end

	// Result descriptors and status
	logic [1:0]  ndesc;
	logic [7:0]  d0_flags;
	logic [31:0] d0_seq, d0_ack, d1_ack;
	logic [10:0] d0_len;
	res_status_t rs;
	logic [15:0] deliver;
	res_t        desc0, desc1, stat;

	always_comb begin
		ndesc    = 2'd0;
		d0_flags = FL_ACK;
		d0_seq   = snd_q;
		d0_ack   = rcv_q;
		d1_ack   = rcv2;
		d0_len   = 11'd0;
		rs       = RS_OK;
		deliver  = 16'd0;
		case (cmd.opcode)
			OP_SEGMENT: begin
				if (drop_seg) begin
					rs = RS_DROP;
				end else if ((cmd.seg_flags & FL_RST) != 8'd0) begin
					rs = RS_RESET;
				end else if (st_q == ST_SYN_SENT) begin
					if (synack_ok) begin
						ndesc  = 2'd1;
						d0_ack = seq_p1;
					end else begin
						rs = RS_DROP;
					end
				end else begin
					ndesc   = 2'({1'b0, has_data} + {1'b0, fin_ok});
					d0_ack  = has_data ? rcv1 : rcv2;
					deliver = delivered ? dlen : 16'd0;
				end
			end
			OP_OPEN: begin
				if (st_q != ST_CLOSED) begin
					rs = RS_NOT_ALLOWED;
				end else begin
					ndesc    = 2'd1;
					d0_flags = FL_SYN;
					d0_seq   = cmd.initial_seq;
					d0_ack   = 32'd0;
				end
			end
			OP_SEND: begin
				if (st_q != ST_ESTAB && st_q != ST_CLOSE_WAIT) begin
					rs = RS_NOT_ALLOWED;
				end else if (cmd.send_length > MaxLen) begin
					rs = RS_TOO_LONG;
				end else if (cmd.send_length == 11'd0) begin
					rs = RS_OK;
				end else if (snd_q != una_q) begin
					rs = RS_NOT_ALLOWED;
				end else begin
					ndesc    = 2'd1;
					d0_flags = FL_ACK | FL_PSH;
					d0_len   = cmd.send_length;
				end
			end
			OP_CLOSE: begin
				if (st_q == ST_ESTAB || st_q == ST_CLOSE_WAIT) begin
					ndesc    = 2'd1;
					d0_flags = FL_ACK | FL_FIN;
				end
			end
			OP_ABORT: begin
				rs = RS_OK;
			end
			default: begin
				rs = RS_NOT_ALLOWED;
			end
		endcase

		desc0 = '{kind: KIND_DESC, tx_flags: d0_flags[4:0], tx_seq: d0_seq, tx_ack: d0_ack,
			tx_length: d0_len, default: '0};
		desc1 = '{kind: KIND_DESC, tx_flags: FL_ACK[4:0], tx_seq: snd_q, tx_ack: d1_ack,
			default: '0};
		stat  = '{kind: KIND_STATUS, deliver_length: deliver, conn_state: st_nxt, status: rs,
			peer_finished: fin_nxt, reset_flag: rst_nxt, last: 1'b1, default: '0};

		// place the status right after the descriptors
		batch.slot[0] = (ndesc == 2'd0) ? stat : desc0;
		batch.slot[1] = (ndesc == 2'd1) ? stat : desc1;
		batch.slot[2] = stat;
		batch.count   = ndesc + 2'd1;
	end

	// Commit the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_CLOSED;
			snd_q <= '0;
			una_q <= '0;
			rcv_q <= '0;
			fin_q <= 1'b0;
			rst_q <= 1'b0;
		end else if (fire) begin
			st_q  <= st_nxt;
			snd_q <= snd_nxt;
			una_q <= una_nxt;
			rcv_q <= rcv_nxt;
			fin_q <= fin_nxt;
			rst_q <= rst_nxt;
		end
	end

	// The status always closes the batch
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (batch.slot[batch.count - 2'd1].last &&
			batch.slot[batch.count - 2'd1].kind == KIND_STATUS))
		else $error("status result not at end of batch");

	// No send while a segment is in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.opcode == OP_SEND && snd_q != una_q |=> snd_q == $past(snd_q))
		else $error("send issued with unacknowledged data");

endmodule

// ===== hw/rtl/tcp_sce_obuf.sv =====
// Result buffer: holds the results of one request and hands them out one per cycle while the receiver is ready.
module tcp_sce_obuf
	import tcp_sce_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  batch_t        batch,
	output logic          can_load,
	tcp_sce_res_if.source res
);

	res_t [MAX_RESULTS-1:0] slot_q;
	logic [1:0]             n_q;
	logic                   pop;

	assign res.valid = (n_q != 2'd0);
	assign res.data  = slot_q[0];
	assign pop       = res.valid && res.ready;
	// take a new batch when empty or when the last result leaves now
	assign can_load  = (n_q == 2'd0) || (pop && n_q == 2'd1);

	// Count of results held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 2'd0;
		end else if (load) begin
			n_q <= batch.count;
		end else if (pop) begin
			n_q <= n_q - 2'd1;
		end
	end

	// Load or advance the slots
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= batch.slot;
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (n_q == 2'd0 || (pop && n_q == 2'd1)))
		else $error("batch loaded over pending results");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.data.last == (n_q == 2'd1)))
		else $error("last flag out of place");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !load && n_q == 2'd1 |=> !res.valid)
		else $error("buffer not empty after last result");

endmodule
